[rtl/core/ucm_pkg.sv]
// ----------------------------------------------------------------------------
// ucm_pkg
// Shared types, class codes, queue sizing and the code point classifier
// for the UTF-8 character class mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package ucm_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } ucm_in_t;

  typedef struct packed {
    logic [6:0]  class_char;
    logic [31:0] cp_val;
  } ucm_out_t;

  typedef struct packed {
    logic valid;
    logic full;
  } ucm_qstat_t;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [6:0] ClsSpace   = 7'h20;
  localparam logic [6:0] ClsNewline = 7'h0A;
  localparam logic [6:0] ClsComma   = 7'h2C;
  localparam logic [6:0] ClsDot     = 7'h2E;
  localparam logic [6:0] ClsBang    = 7'h21;
  localparam logic [6:0] ClsQuest   = 7'h3F;
  localparam logic [6:0] ClsDigit   = 7'h30;
  localparam logic [6:0] ClsUpper   = 7'h41;
  localparam logic [6:0] ClsLower   = 7'h61;
  localparam logic [6:0] ClsHira    = 7'h68;
  localparam logic [6:0] ClsKata    = 7'h6B;
  localparam logic [6:0] ClsKanji   = 7'h4B;
  localparam logic [6:0] ClsOther   = 7'h78;

  function automatic logic [6:0] classify(input logic [31:0] c);
    logic [6:0] r;
    r = ClsOther;
    case (c)
      32'h09, 32'h20, 32'h00A0, 32'h202F, 32'h205F,
      32'h3000, 32'hFEFF, 32'h0D:                    r = ClsSpace;
      32'h0A:                                        r = ClsNewline;
      32'h2C, 32'h3001, 32'hFF0C, 32'hFF64:          r = ClsComma;
      32'h2E, 32'h3002, 32'hFF0E, 32'hFF61:          r = ClsDot;
      32'h21, 32'hFF01:                              r = ClsBang;
      32'h3F, 32'hFF1F:                              r = ClsQuest;
      default: begin
        if (c inside {[32'h2000:32'h200B]}) begin
          r = ClsSpace;
        end else if (c inside {[32'h30:32'h39], [32'hFF10:32'hFF19]}) begin
          r = ClsDigit;
        end else if (c inside {[32'h41:32'h5A], [32'hFF21:32'hFF3A]}) begin
          r = ClsUpper;
        end else if (c inside {[32'h61:32'h7A], [32'hFF41:32'hFF5A]}) begin
          r = ClsLower;
        end else if (c inside {[32'h3040:32'h309F]}) begin
          r = ClsHira;
        end else if (c inside {[32'h30A0:32'h30FF], [32'h31F0:32'h31FF],
                               [32'hFF66:32'hFF9F]}) begin
          r = ClsKata;
        end else if (c inside {[32'h3400:32'h4DBF], [32'h4E00:32'h9FFF],
                               [32'hF900:32'hFAFF], [32'h20000:32'h2FA1F]}) begin
          r = ClsKanji;
        end else begin
          r = ClsOther;
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ucm_front.sv]
// ----------------------------------------------------------------------------
// ucm_front
// Byte decoder: tracks the open sequence and writes each finished code point
// into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ucm_front import ucm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire ucm_in_t     in_i,
  output      logic        wr_o,
  output      logic [31:0] cp_o
);

  logic [31:0] acc_q, acc_d, acc_new;
  logic [2:0]  pend_q, pend_d, pend_new, run;
  logic        done;
  logic [7:0]  b;
  logic [7:0]  mask;

  function automatic logic [2:0] lead_run(input logic [6:0] v);
    logic [2:0] r;
    logic       stop;
    r = 3'd0;
    stop = 1'b0;
    for (int i = 6; i >= 0; i--) begin
      if (!stop && v[i]) begin
        r = r + 3'd1;
      end else begin
        stop = 1'b1;
      end
    end
    return r;
  endfunction

  assign b    = in_i.data_byte;
  assign run  = lead_run(b[6:0]);
  assign mask = 8'h3F >> run;

  always_comb begin
    acc_new  = acc_q;
    pend_new = pend_q;
    done     = 1'b0;
    if (pend_q == 3'd0) begin
      if (!b[7]) begin
        acc_new = {24'd0, b};
        done    = 1'b1;
      end else begin
        acc_new  = (run >= 3'd6) ? 32'd0 : {24'd0, b & mask};
        pend_new = run;
        done     = (run == 3'd0);
      end
    end else begin
      acc_new  = {acc_q[25:0], b[5:0]};
      pend_new = pend_q - 3'd1;
      done     = (pend_new == 3'd0);
    end
  end

  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    if (accept_i) begin
      if (done || in_i.end_of_text) begin
        acc_d  = 32'd0;
        pend_d = 3'd0;
      end else begin
        acc_d  = acc_new;
        pend_d = pend_new;
      end
    end
  end

  assign wr_o = accept_i && done;
  assign cp_o = acc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 32'd0;
      pend_q <= 3'd0;
    end else begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ucm_queue.sv]
// ----------------------------------------------------------------------------
// ucm_queue
// Small queue of decoded code points between the decoder and the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module ucm_queue import ucm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_i,
  input  wire logic [31:0] wr_data_i,
  input  wire logic        rd_i,
  output      logic [31:0] rd_data_o,
  output      ucm_qstat_t  stat_o
);

  logic [31:0]      mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign rd_data_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ucm_back.sv]
// ----------------------------------------------------------------------------
// ucm_back
// Classifier and output register: takes code points from the queue and holds
// each result until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module ucm_back import ucm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire logic [31:0] q_data_i,
  output      logic        q_rd_o,
  input  wire logic        pop,
  output      logic        empty,
  output      ucm_out_t    out_o
);

  logic     vld_q, vld_d;
  ucm_out_t res_q, res_d;

  assign q_rd_o = q_valid_i && (!vld_q || pop);

  always_comb begin
    vld_d = vld_q;
    res_d = res_q;
    if (q_rd_o) begin
      vld_d            = 1'b1;
      res_d.class_char = classify(q_data_i);
      res_d.cp_val     = q_data_i;
    end else if (pop) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign empty = !vld_q;
  assign out_o = res_q;

endmodule

`default_nettype wire

[rtl/core/utf8_char_class_mapper_top.sv]
// ----------------------------------------------------------------------------
// utf8_char_class_mapper_top
// Lenient UTF-8 decoder that tags every finished code point with a class
// character.
//
//   channel   handshake        payload
//   request   push / full      in_i  (data_byte, end_of_text)
//   result    empty / pop      out_o (class_char, cp_val)
//
// One byte is taken per cycle while full is low; the decoder state is updated in the same cycle.
// A finished code point passes through the queue and then the classifier output
// register on its way to the result ports.
// Reset clears the open sequence and the queue, and marks the output register empty.
// full rises when the four-entry queue is full behind a held result.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_char_class_mapper_top import ucm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output      logic     full,
  input  wire ucm_in_t  in_i,
  output      logic     empty,
  input  wire logic     pop,
  output      ucm_out_t out_o
);

  logic        accept;
  logic        q_wr;
  logic        q_rd;
  logic [31:0] q_wr_data;
  logic [31:0] q_rd_data;
  ucm_qstat_t  q_stat;

  assign full   = q_stat.full;
  assign accept = push && !full;

  ucm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .wr_o     (q_wr),
    .cp_o     (q_wr_data)
  );

  ucm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .rd_i      (q_rd),
    .rd_data_o (q_rd_data),
    .stat_o    (q_stat)
  );

  ucm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_stat.valid),
    .q_data_i  (q_rd_data),
    .q_rd_o    (q_rd),
    .pop       (pop),
    .empty     (empty),
    .out_o     (out_o)
  );

  // queue only written by an accepted request
  a_wr_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr |-> accept)
    else $error("queue write without accepted request");

  // queue only read when it holds an entry
  a_rd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> q_stat.valid)
    else $error("queue read while empty");

  // a popped result with nothing queued leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !q_stat.valid) |=> empty)
    else $error("result reappeared after pop");

  // a held result does not change while it waits
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("waiting result changed");

endmodule

`default_nettype wire
